### hdl/assert_macros.svh
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/twis_pkg.sv
package twis_pkg;

   localparam int NODE_COUNT   = 1024;
   localparam int LETTER_COUNT = 26;
   localparam int NODE_W       = $clog2(NODE_COUNT);
   localparam int FREE_W       = $clog2(NODE_COUNT + 1);
   localparam int TABLE_SIZE   = NODE_COUNT * LETTER_COUNT;
   localparam int SLOT_W       = $clog2(TABLE_SIZE);
   localparam int LETTER_W     = (LETTER_COUNT > 1) ? $clog2(LETTER_COUNT) : 1;
   localparam int CHAR_W       = 8;

   localparam logic [CHAR_W-1:0] FIRST_LETTER = 8'h61;
   localparam logic [CHAR_W-1:0] LAST_LETTER  = 8'h7a;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_FLAG
   } state_type;

   typedef struct packed {
      logic              child_we;
      logic              child_re;
      logic [SLOT_W-1:0] child_addr;
      logic [NODE_W-1:0] child_wdata;
      logic              flag_we;
      logic              flag_re;
      logic [NODE_W-1:0] flag_addr;
      logic              flag_wdata;
   } mem_req_type;

   // {valid, letter index}
   function automatic logic [LETTER_W:0] letter_code(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] diff;
      logic              ok;
      diff = ch - FIRST_LETTER;
      ok   = (ch >= FIRST_LETTER) && (ch <= LAST_LETTER)
             && (diff < CHAR_W'(LETTER_COUNT));
      return {ok, diff[LETTER_W-1:0]};
   endfunction

endpackage

### hdl/trie_word_insert_search_top.sv
// Trie of lowercase words kept in a pool of 1024 nodes. Words stream in one
// byte per character on req, tuser selecting insert (0) or search (1) and
// tlast marking the final byte; bytes outside a..z are skipped. One response
// word comes out per final byte. After reset the block sweeps its 26624-entry
// child table, one entry a cycle, before req_tready first rises. A skipped
// byte ends in idle, a letter goes through a child table read, then update
// with write-back, and a final byte also through the flag state, which holds
// while the response stalls; these steps are set by the single port of the
// child table and the dependence of each letter on the node reached before.
module trie_word_insert_search_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] character
   input  logic       req_tuser,  // [0] operation
   input  logic       req_tlast,  // last_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata   // [0] found, [1] pool_full, [7:2] zero
);

   twis_pkg::state_type state_ff, state_in;

   logic [twis_pkg::NODE_W-1:0] node_ff, node_in;
   logic [twis_pkg::FREE_W-1:0] free_ff, free_in;
   logic                        missed_ff, missed_in;
   logic                        overflow_ff, overflow_in;
   logic [twis_pkg::SLOT_W-1:0] clr_ff, clr_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   twis_pkg::op_type            op_ff, op_in;
   logic                        last_ff, last_in;
   logic [twis_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic                        found_ff, found_in;
   logic                        full_ff, full_in;

   twis_pkg::mem_req_type       mem_req;
   logic [twis_pkg::NODE_W-1:0] child_q;
   logic                        flag_q;

   logic                          req_fire;
   logic                          rsp_free;
   logic [twis_pkg::LETTER_W:0]   code;
   logic                          use_letter;
   twis_pkg::op_type              req_op;
   logic [twis_pkg::SLOT_W-1:0]   req_slot;

   twis_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .child_q (child_q),
      .flag_q  (flag_q)
   );

   assign req_tready = (state_ff == twis_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, full_ff, found_ff};

   assign req_op   = twis_pkg::op_type'(req_tuser);
   assign code     = twis_pkg::letter_code(req_tdata);
   assign req_slot = twis_pkg::SLOT_W'(node_ff) * twis_pkg::SLOT_W'(twis_pkg::LETTER_COUNT)
                     + twis_pkg::SLOT_W'(code[twis_pkg::LETTER_W-1:0]);
   assign use_letter = code[twis_pkg::LETTER_W]
                       && ((req_op == twis_pkg::OP_SEARCH) ? !missed_ff : !overflow_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         twis_pkg::ST_CLEAR: begin
            if (clr_ff == twis_pkg::SLOT_W'(twis_pkg::TABLE_SIZE - 1)) begin
               state_in = twis_pkg::ST_IDLE;
            end
         end
         twis_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (use_letter) begin
                  state_in = twis_pkg::ST_LOOK;
               end else if (req_tlast) begin
                  state_in = twis_pkg::ST_FLAG;
               end
            end
         end
         twis_pkg::ST_LOOK: begin
            state_in = last_ff ? twis_pkg::ST_FLAG : twis_pkg::ST_IDLE;
         end
         twis_pkg::ST_FLAG: begin
            if (rsp_free) begin
               state_in = twis_pkg::ST_IDLE;
            end
         end
         default: state_in = twis_pkg::ST_CLEAR;
      endcase
   end

   // datapath and memory requests
   always_comb begin
      node_in      = node_ff;
      free_in      = free_ff;
      missed_in    = missed_ff;
      overflow_in  = overflow_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      op_in        = op_ff;
      last_in      = last_ff;
      slot_in      = slot_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      mem_req      = '0;
      unique case (state_ff)
         twis_pkg::ST_CLEAR: begin
            clr_in               = clr_ff + 1'b1;
            mem_req.child_we     = 1'b1;
            mem_req.child_addr   = clr_ff;
            mem_req.flag_we      = (clr_ff < twis_pkg::SLOT_W'(twis_pkg::NODE_COUNT));
            mem_req.flag_addr    = clr_ff[twis_pkg::NODE_W-1:0];
         end
         twis_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in   = req_op;
               last_in = req_tlast;
               slot_in = req_slot;
               if (use_letter) begin
                  mem_req.child_re   = 1'b1;
                  mem_req.child_addr = req_slot;
               end else if (req_tlast) begin
                  mem_req.flag_re   = 1'b1;
                  mem_req.flag_addr = node_ff;
               end
            end
         end
         twis_pkg::ST_LOOK: begin
            if (op_ff == twis_pkg::OP_SEARCH) begin
               if (child_q == '0) begin
                  missed_in = 1'b1;
               end else begin
                  node_in = child_q;
               end
            end else if (child_q != '0) begin
               node_in = child_q;
            end else if (free_ff < twis_pkg::FREE_W'(twis_pkg::NODE_COUNT)) begin
               node_in             = free_ff[twis_pkg::NODE_W-1:0];
               free_in             = free_ff + 1'b1;
               mem_req.child_we    = 1'b1;
               mem_req.child_addr  = slot_ff;
               mem_req.child_wdata = free_ff[twis_pkg::NODE_W-1:0];
            end else begin
               overflow_in = 1'b1;
            end
            mem_req.flag_re   = last_ff;
            mem_req.flag_addr = node_in;
         end
         twis_pkg::ST_FLAG: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               found_in     = (op_ff == twis_pkg::OP_SEARCH) && !missed_ff && flag_q;
               full_in      = (op_ff == twis_pkg::OP_INSERT) && overflow_ff;
               if ((op_ff == twis_pkg::OP_INSERT) && !overflow_ff) begin
                  mem_req.flag_we    = 1'b1;
                  mem_req.flag_addr  = node_ff;
                  mem_req.flag_wdata = 1'b1;
               end
               node_in     = '0;
               missed_in   = 1'b0;
               overflow_in = 1'b0;
            end
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= twis_pkg::ST_CLEAR;
         node_ff      <= '0;
         free_ff      <= twis_pkg::FREE_W'(1);
         missed_ff    <= 1'b0;
         overflow_ff  <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         free_ff      <= free_in;
         missed_ff    <= missed_in;
         overflow_ff  <= overflow_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      last_ff  <= last_in;
      slot_ff  <= slot_in;
      found_ff <= found_in;
      full_ff  <= full_in;
   end

endmodule

### hdl/twis_store.sv
module twis_store (
   input  logic                      clock,
   input  twis_pkg::mem_req_type     mem_req,
   output logic [twis_pkg::NODE_W-1:0] child_q,
   output logic                      flag_q
);

   logic [twis_pkg::NODE_W-1:0] child_mem [twis_pkg::TABLE_SIZE];
   logic                        flag_mem  [twis_pkg::NODE_COUNT];

   always_ff @(posedge clock) begin
      if (mem_req.child_we) begin
         child_mem[mem_req.child_addr] <= mem_req.child_wdata;
      end
      if (mem_req.child_re) begin
         child_q <= child_mem[mem_req.child_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.flag_we) begin
         flag_mem[mem_req.flag_addr] <= mem_req.flag_wdata;
      end
      if (mem_req.flag_re) begin
         flag_q <= flag_mem[mem_req.flag_addr];
      end
   end

endmodule

### hdl/twis_checker.sv
`include "assert_macros.svh"

module twis_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response word changed while stalled")
   `ASSERT_IMPLIES(a_rsp_excl, clock, reset, rsp_tvalid, !(rsp_tdata[0] && rsp_tdata[1]), "found and pool_full both set")
   `ASSERT_IMPLIES(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[7:2] == 6'b0, "response padding not zero")
   `ASSERT_IMPLIES(a_clear_hold, clock, reset, $fell(reset), !req_tready, "ready during table clear")
   `ASSERT_NEXT(a_busy_after, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "no response cycle after final byte")

endmodule

bind trie_word_insert_search_top twis_checker u_twis_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### test/trie_word_insert_search_top_tb.sv
`timescale 1ns / 100ps

module trie_word_insert_search_top_tb;

   localparam int CLOCK_HALF     = 2;
   localparam int WATCHDOG_LIMIT = 100000;
   localparam int RSP_HOLD_LEN   = 400;
   localparam int DRAIN_CYCLES   = 20;
   localparam int LONG_WORD_LEN  = 150;

   typedef struct {
      bit found;
      bit pool_full;
   } word_outcome_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tuser  = 1'b0;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;

   // trie image kept alongside the block
   bit [twis_pkg::NODE_W-1:0] child_links [twis_pkg::TABLE_SIZE];
   bit                        word_end    [twis_pkg::NODE_COUNT];
   int                        cur_node      = 0;
   int                        free_node     = 1;
   bit                        walk_missed   = 1'b0;
   bit                        walk_overflow = 1'b0;

   word_outcome_type outcomes_q[$];

   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   bit rsp_hold_req   = 1'b0;
   int rsp_hold_left  = 0;
   int quiet_cycles   = 0;

   trie_word_insert_search_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLOCK_HALF) clock = ~clock;

   function automatic bit letter_index(input logic [7:0] ch, output int idx);
      idx = int'(ch) - int'(twis_pkg::FIRST_LETTER);
      return (ch >= twis_pkg::FIRST_LETTER) && (ch <= twis_pkg::LAST_LETTER)
             && (idx < twis_pkg::LETTER_COUNT);
   endfunction

   function automatic logic [7:0] random_letter(input int span);
      return 8'(int'(twis_pkg::FIRST_LETTER) + $urandom_range(span - 1));
   endfunction

   task automatic trie_walk(input twis_pkg::op_type op, input logic [7:0] ch,
                            input logic fin);
      int               idx;
      int               slot;
      int               child;
      word_outcome_type res;
      if (letter_index(ch, idx)) begin
         slot  = cur_node * twis_pkg::LETTER_COUNT + idx;
         child = child_links[slot];
         if (op == twis_pkg::OP_SEARCH) begin
            if (!walk_missed) begin
               if (child == 0) walk_missed = 1'b1;
               else cur_node = child;
            end
         end else if (!walk_overflow) begin
            if (child != 0) begin
               cur_node = child;
            end else if (free_node < twis_pkg::NODE_COUNT) begin
               child_links[slot] = twis_pkg::NODE_W'(free_node);
               cur_node = free_node;
               free_node++;
            end else begin
               walk_overflow = 1'b1;
            end
         end
      end
      if (fin) begin
         if (op == twis_pkg::OP_SEARCH) begin
            res.found     = !walk_missed && word_end[cur_node];
            res.pool_full = 1'b0;
         end else begin
            if (!walk_overflow) word_end[cur_node] = 1'b1;
            res.found     = 1'b0;
            res.pool_full = walk_overflow;
         end
         outcomes_q.push_back(res);
         cur_node      = 0;
         walk_missed   = 1'b0;
         walk_overflow = 1'b0;
      end
   endtask

   task automatic send_byte(input twis_pkg::op_type op, input logic [7:0] ch,
                            input logic fin);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= op;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      trie_walk(op, ch, fin);
   endtask

   task automatic send_word(input twis_pkg::op_type op, input string w);
      for (int i = 0; i < w.len(); i++) send_byte(op, w[i], i == w.len() - 1);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outcomes_q.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d, want %0d", what, got, want);
      mismatch_count++;
   endtask

   task automatic test_directed();
      send_byte(twis_pkg::OP_SEARCH, 8'h00, 1'b1);
      send_byte(twis_pkg::OP_INSERT, 8'hff, 1'b1);
      send_byte(twis_pkg::OP_SEARCH, 8'h60, 1'b1);
      send_word(twis_pkg::OP_INSERT, "a{z");
      send_word(twis_pkg::OP_SEARCH, "az");
      send_word(twis_pkg::OP_SEARCH, "a");
      send_word(twis_pkg::OP_SEARCH, "azb");
      send_word(twis_pkg::OP_SEARCH, "qaz");
      // operation switched inside a word
      send_byte(twis_pkg::OP_INSERT, "a", 1'b0);
      send_byte(twis_pkg::OP_SEARCH, "z", 1'b1);
      send_byte(twis_pkg::OP_SEARCH, "q", 1'b0);
      send_byte(twis_pkg::OP_INSERT, "b", 1'b1);
      send_word(twis_pkg::OP_SEARCH, "B`b");
      wait_drained();
   endtask

   task automatic test_random_words(input int n_items);
      int               done;
      int               len;
      int               idx;
      bit               wide;
      twis_pkg::op_type op;
      twis_pkg::op_type byte_op;
      logic [7:0]       ch;
      done = 0;
      while (done < n_items) begin
         if ($urandom_range(99) < 85) begin
            op   = twis_pkg::op_type'($urandom_range(1));
            len  = $urandom_range(5);
            wide = ($urandom_range(9) == 0);
            if (len == 0) begin
               do ch = 8'($urandom_range(255)); while (letter_index(ch, idx));
               send_byte(op, ch, 1'b1);
               done++;
            end
            for (int i = 0; i < len; i++) begin
               byte_op = ($urandom_range(19) == 0) ? twis_pkg::op_type'(~op) : op;
               ch = wide ? random_letter(twis_pkg::LETTER_COUNT) : random_letter(4);
               if ($urandom_range(19) == 0) ch = 8'($urandom_range(255));
               send_byte(byte_op, ch, i == len - 1);
               done++;
            end
         end else begin
            op = twis_pkg::op_type'($urandom_range(1));
            ch = 8'($urandom_range(255));
            send_byte(op, ch, $urandom_range(3) == 0);
            done++;
         end
      end
   endtask

   task automatic test_receiver_hold();
      int len;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      rsp_hold_req  = 1'b1;
      for (int w = 0; w < 60; w++) begin
         len = $urandom_range(1, 2);
         for (int i = 0; i < len; i++)
            send_byte(twis_pkg::op_type'($urandom_range(1)), random_letter(4),
                      i == len - 1);
      end
      wait_drained();
   endtask

   task automatic test_pool_exhaustion();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (free_node < twis_pkg::NODE_COUNT) begin
         for (int i = 0; i < LONG_WORD_LEN; i++)
            send_byte(twis_pkg::OP_INSERT, random_letter(twis_pkg::LETTER_COUNT),
                      i == LONG_WORD_LEN - 1);
      end
      for (int w = 0; w < 3; w++) begin
         for (int i = 0; i < 8; i++)
            send_byte(twis_pkg::OP_INSERT, random_letter(twis_pkg::LETTER_COUNT), i == 7);
      end
      test_random_words(40);
      wait_drained();
   endtask

   // receiver side: random stalls plus an occasional long hold
   always @(negedge clock) begin
      if (rsp_hold_req) begin
         rsp_hold_left = RSP_HOLD_LEN;
         rsp_hold_req  = 1'b0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      word_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcomes_q.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, 0);
         end else begin
            want = outcomes_q.pop_front();
            if (rsp_tdata[0] !== want.found) report_mismatch("found", rsp_tdata[0], want.found);
            if (rsp_tdata[1] !== want.pool_full)
               report_mismatch("pool_full", rsp_tdata[1], want.pool_full);
            if (rsp_tdata[7:2] !== 6'd0) report_mismatch("pad bits", rsp_tdata[7:2], 0);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 9;
      recv_idle_pct = 83;
      test_directed();
      test_random_words(100);
      wait_drained();

      send_idle_pct = 83;
      recv_idle_pct = 9;
      test_random_words(100);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_words(100);
      wait_drained();

      test_receiver_hold();
      test_pool_exhaustion();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
